### hw/rtl/fmd_pkg.sv
// Shared constants, register codes and types of the frame motion detector.
package fmd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int CFG_SIZE_W = 11;
  localparam int COUNT_W    = 21;
  localparam int BOX_W      = 10;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_THRESHOLD = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_COUNT_THRESHOLD = 2'd3;

  localparam logic [CFG_SIZE_W-1:0] FRAME_WIDTH_RST     = 11'd320;
  localparam logic [CFG_SIZE_W-1:0] FRAME_HEIGHT_RST    = 11'd240;
  localparam logic [PIX_W-1:0]      PIXEL_THRESHOLD_RST = 8'd16;
  localparam logic [COUNT_W-1:0]    COUNT_THRESHOLD_RST = 21'd100;

  typedef struct packed {
    logic [CFG_SIZE_W-1:0] frame_width;
    logic [CFG_SIZE_W-1:0] frame_height;
    logic [PIX_W-1:0]      pixel_threshold;
    logic [COUNT_W-1:0]    count_threshold;
  } fmd_cfg_t;

  typedef struct packed {
    logic               motion_detected;
    logic [COUNT_W-1:0] changed_count;
    logic [BOX_W-1:0]   box_left;
    logic [BOX_W-1:0]   box_top;
    logic [BOX_W-1:0]   box_right;
    logic [BOX_W-1:0]   box_bottom;
  } fmd_result_t;

endpackage

### hw/rtl/fmd_cfg.sv
// APB-style configuration register file of the frame motion detector.
module fmd_cfg
  import fmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output fmd_cfg_t              cfg_o
);

  fmd_cfg_t cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:     cfg_d.frame_width     = pwdata[CFG_SIZE_W-1:0];
        REG_FRAME_HEIGHT:    cfg_d.frame_height    = pwdata[CFG_SIZE_W-1:0];
        REG_PIXEL_THRESHOLD: cfg_d.pixel_threshold = pwdata[PIX_W-1:0];
        REG_COUNT_THRESHOLD: cfg_d.count_threshold = pwdata[COUNT_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:
        prdata = APB_DATA_W'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:
        prdata = APB_DATA_W'(cfg_q.frame_height);
      REG_PIXEL_THRESHOLD:
        prdata = APB_DATA_W'(cfg_q.pixel_threshold);
      REG_COUNT_THRESHOLD:
        prdata = APB_DATA_W'(cfg_q.count_threshold);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width     <= FRAME_WIDTH_RST;
      cfg_q.frame_height    <= FRAME_HEIGHT_RST;
      cfg_q.pixel_threshold <= PIXEL_THRESHOLD_RST;
      cfg_q.count_threshold <= COUNT_THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hw/rtl/fmd_accum.sv
// Pixel difference test, raster position counters and per-frame accumulators.
module fmd_accum
  import fmd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fmd_cfg_t         cfg_i,
  input  logic             step_i,
  input  logic [PIX_W-1:0] new_pixel_i,
  input  logic [PIX_W-1:0] old_pixel_i,
  output logic             frame_end_o,
  output fmd_result_t      result_o
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int SWX = ($clog2(MAX_WIDTH + 1) > CFG_SIZE_W) ? $clog2(MAX_WIDTH + 1) : CFG_SIZE_W;
  localparam int SWY = ($clog2(MAX_HEIGHT + 1) > CFG_SIZE_W) ?
                       $clog2(MAX_HEIGHT + 1) : CFG_SIZE_W;
  localparam logic [SWX-1:0] MAXW = SWX'(MAX_WIDTH);
  localparam logic [SWY-1:0] MAXH = SWY'(MAX_HEIGHT);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [XW-1:0]      col_q, col_d, min_col_q, min_col_d, max_col_q, max_col_d;
  logic [YW-1:0]      line_q, line_d, min_line_q, min_line_d, max_line_q, max_line_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               any_q, any_d;

  logic [SWX-1:0] w_ext, w_eff;
  logic [SWY-1:0] h_ext, h_eff;
  logic           col_end, line_end, changed;
  logic [PIX_W-1:0] diff;

  // Clamp the frame size to 1..MAX.
  assign w_ext = SWX'(cfg_i.frame_width);
  assign h_ext = SWY'(cfg_i.frame_height);
  assign w_eff = (w_ext == '0) ? SWX'(1) : ((w_ext > MAXW) ? MAXW : w_ext);
  assign h_eff = (h_ext == '0) ? SWY'(1) : ((h_ext > MAXH) ? MAXH : h_ext);

  assign col_end     = SWX'(col_q) >= (w_eff - SWX'(1));
  assign line_end    = SWY'(line_q) >= (h_eff - SWY'(1));
  assign frame_end_o = col_end && line_end;

  assign diff    = (new_pixel_i >= old_pixel_i) ? (new_pixel_i - old_pixel_i)
                                                : (old_pixel_i - new_pixel_i);
  assign changed = diff > cfg_i.pixel_threshold;

  // Updated accumulators, including the current pixel.
  always_comb begin
    cnt_d      = cnt_q;
    any_d      = any_q;
    min_col_d  = min_col_q;
    min_line_d = min_line_q;
    max_col_d  = max_col_q;
    max_line_d = max_line_q;
    if (changed) begin
      if (cnt_q != COUNT_MAX) begin
        cnt_d = cnt_q + COUNT_W'(1);
      end
      any_d = 1'b1;
      if (!any_q) begin
        min_col_d  = col_q;
        min_line_d = line_q;
        max_col_d  = col_q;
        max_line_d = line_q;
      end else begin
        if (col_q < min_col_q)   min_col_d  = col_q;
        if (line_q < min_line_q) min_line_d = line_q;
        if (col_q > max_col_q)   max_col_d  = col_q;
        if (line_q > max_line_q) max_line_d = line_q;
      end
    end
  end

  always_comb begin
    col_d  = col_q + XW'(1);
    line_d = line_q;
    if (col_end) begin
      col_d  = '0;
      line_d = line_q + YW'(1);
    end
  end

  assign result_o.motion_detected = cnt_d > cfg_i.count_threshold;
  assign result_o.changed_count   = cnt_d;
  assign result_o.box_left        = any_d ? BOX_W'(min_col_d)  : '0;
  assign result_o.box_top         = any_d ? BOX_W'(min_line_d) : '0;
  assign result_o.box_right       = any_d ? BOX_W'(max_col_d)  : '0;
  assign result_o.box_bottom      = any_d ? BOX_W'(max_line_d) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      line_q     <= '0;
      cnt_q      <= '0;
      any_q      <= 1'b0;
      min_col_q  <= '0;
      min_line_q <= '0;
      max_col_q  <= '0;
      max_line_q <= '0;
    end else if (step_i) begin
      if (frame_end_o) begin
        col_q      <= '0;
        line_q     <= '0;
        cnt_q      <= '0;
        any_q      <= 1'b0;
        min_col_q  <= '0;
        min_line_q <= '0;
        max_col_q  <= '0;
        max_line_q <= '0;
      end else begin
        col_q      <= col_d;
        line_q     <= line_d;
        cnt_q      <= cnt_d;
        any_q      <= any_d;
        min_col_q  <= min_col_d;
        min_line_q <= min_line_d;
        max_col_q  <= max_col_d;
        max_line_q <= max_line_d;
      end
    end
  end

endmodule

### hw/rtl/frame_motion_detect.sv
// Top level of the frame-difference motion detector with bounding box.
//
//  channel   direction  handshake                payload
//  --------  ---------  -----------------------  ------------------------------------------
//  pixel     in         in_valid_i / in_stall_o  new_pixel_i, old_pixel_i
//  result    out        out_valid_o / out_stall_i motion_detected_o, changed_count_o, box_*_o
//  config    in         APB psel/penable/pwrite  frame size, pixel and count thresholds
//
// One pixel transaction per clock while the input does not stall. A pixel lands
// in the input register and is tested and folded into the frame accumulators
// on the next edge, unless it is the frame's last pixel held behind a busy result;
// the result register loads on the edge that folds in that last pixel.
// Reset clears the position counters, accumulators and both valid flags.
// The input stalls only when the frame's last pixel waits behind a result
// that the output side has not yet taken.
module frame_motion_detect
  import fmd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      new_pixel_i,
  input  logic [PIX_W-1:0]      old_pixel_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  motion_detected_o,
  output logic [COUNT_W-1:0]    changed_count_o,
  output logic [BOX_W-1:0]      box_left_o,
  output logic [BOX_W-1:0]      box_top_o,
  output logic [BOX_W-1:0]      box_right_o,
  output logic [BOX_W-1:0]      box_bottom_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  fmd_cfg_t    cfg;
  fmd_result_t result;
  fmd_result_t out_res_q;

  logic             pix_valid_q, pix_valid_d;
  logic [PIX_W-1:0] new_q, old_q;
  logic             out_valid_q, out_valid_d;
  logic             in_accept, pix_step, frame_end, out_free, out_load;

  fmd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fmd_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (pix_step),
    .new_pixel_i (new_q),
    .old_pixel_i (old_q),
    .frame_end_o (frame_end),
    .result_o    (result)
  );

  // The result register is free when empty or when its transaction completes now.
  assign out_free = !out_valid_q || !out_stall_i;

  // Advance the held pixel unless it closes a frame and the result slot is busy.
  assign pix_step   = pix_valid_q && (!frame_end || out_free);
  assign out_load   = pix_step && frame_end;
  assign in_stall_o = pix_valid_q && !pix_step;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    pix_valid_d = pix_valid_q;
    if (in_accept) begin
      pix_valid_d = 1'b1;
    end else if (pix_step) begin
      pix_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pix_valid_q <= pix_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: the pixel pair loads on accept, the result on out_load; both hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      new_q <= new_pixel_i;
      old_q <= old_pixel_i;
    end
    if (out_load) begin
      out_res_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign motion_detected_o = out_res_q.motion_detected;
  assign changed_count_o   = out_res_q.changed_count;
  assign box_left_o        = out_res_q.box_left;
  assign box_top_o         = out_res_q.box_top;
  assign box_right_o       = out_res_q.box_right;
  assign box_bottom_o      = out_res_q.box_bottom;

`ifndef SYNTH
  // A stall on the input only ever comes from a frame end blocked by the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (pix_valid_q && frame_end && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked frame end");

  // A frame end that advances must present a result next cycle.
  a_frame_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("frame end lost its result");

  // A result appears only after a frame end advanced.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(out_load))
    else $error("result without a frame end");
`endif

endmodule

### tb/tb_frame_motion_detect.sv
// Self-checking testbench for the frame motion detector: pixel stimulus, APB setup, frame reports.
module tb_frame_motion_detect;
  timeunit 1ns;
  timeprecision 1ps;

  import fmd_pkg::*;

  // Give up well beyond the slowest legal run (a few thousand transactions, long stalls).
  localparam int CYCLE_LIMIT = 400000;
  // Leave a margin after the last report before touching registers.
  localparam int SETTLE_CYCLES = 4;

  // Keeps a private copy of the register file and the per-frame accumulators,
  // folds each accepted pixel into them and queues the report a frame should give.
  class frame_report_board;
    logic [CFG_SIZE_W-1:0] width_reg     = FRAME_WIDTH_RST;
    logic [CFG_SIZE_W-1:0] height_reg    = FRAME_HEIGHT_RST;
    logic [PIX_W-1:0]      pix_thr_reg   = PIXEL_THRESHOLD_RST;
    logic [COUNT_W-1:0]    count_thr_reg = COUNT_THRESHOLD_RST;

    logic [BOX_W-1:0]   col = '0, line = '0;
    logic [BOX_W-1:0]   min_col = '0, min_line = '0, max_col = '0, max_line = '0;
    logic [COUNT_W-1:0] changed = '0;
    bit                 found = 1'b0;

    fmd_result_t awaited_reports[$];
    int errors = 0;
    int pixels_seen = 0;
    int reports_predicted = 0;
    int reports_checked = 0;
    int motion_reports = 0;

    function int pending();
      return awaited_reports.size();
    endfunction

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:     width_reg     = data[CFG_SIZE_W-1:0];
        REG_FRAME_HEIGHT:    height_reg    = data[CFG_SIZE_W-1:0];
        REG_PIXEL_THRESHOLD: pix_thr_reg   = data[PIX_W-1:0];
        REG_COUNT_THRESHOLD: count_thr_reg = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Fold one pixel pair into the frame; at the last pixel queue the report.
    function void note_pixel(logic [PIX_W-1:0] cur, logic [PIX_W-1:0] prev);
      int diff, w, h;
      fmd_result_t rep;
      diff = (cur >= prev) ? int'(cur) - int'(prev) : int'(prev) - int'(cur);
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg));
      h = (height_reg == 0) ? 1 :
          ((height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(height_reg));
      pixels_seen++;
      if (diff > int'(pix_thr_reg)) begin
        if (changed != '1) changed++;
        if (!found) begin
          found = 1'b1;
          min_col = col; max_col = col;
          min_line = line; max_line = line;
        end else begin
          if (col < min_col) min_col = col;
          if (line < min_line) min_line = line;
          if (col > max_col) max_col = col;
          if (line > max_line) max_line = line;
        end
      end
      if (int'(col) >= w - 1) begin
        if (int'(line) >= h - 1) begin
          rep.motion_detected = (changed > count_thr_reg);
          rep.changed_count   = changed;
          rep.box_left   = found ? min_col  : '0;
          rep.box_top    = found ? min_line : '0;
          rep.box_right  = found ? max_col  : '0;
          rep.box_bottom = found ? max_line : '0;
          awaited_reports.push_back(rep);
          reports_predicted++;
          if (rep.motion_detected) motion_reports++;
          col = '0; line = '0; changed = '0; found = 1'b0;
          min_col = '0; min_line = '0; max_col = '0; max_line = '0;
        end else begin
          col = '0;
          line++;
        end
      end else begin
        col++;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_report(fmd_result_t seen);
      fmd_result_t want;
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got count %0d box %0d,%0d,%0d,%0d",
                 $time, seen.changed_count, seen.box_left, seen.box_top, seen.box_right,
                 seen.box_bottom);
        errors++;
        return;
      end
      want = awaited_reports.pop_front();
      reports_checked++;
      compare_field("motion_detected", want.motion_detected, seen.motion_detected);
      compare_field("changed_count", want.changed_count, seen.changed_count);
      compare_field("box_left", want.box_left, seen.box_left);
      compare_field("box_top", want.box_top, seen.box_top);
      compare_field("box_right", want.box_right, seen.box_right);
      compare_field("box_bottom", want.box_bottom, seen.box_bottom);
    endfunction
  endclass

  // Clock, reset and every block input start at a known value.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic [PIX_W-1:0]   new_pixel = '0;
  logic [PIX_W-1:0]   old_pixel = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic               motion_detected_o;
  logic [COUNT_W-1:0] changed_count_o;
  logic [BOX_W-1:0]   box_left_o, box_top_o, box_right_o, box_bottom_o;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  frame_report_board sb = new;

  // Idling odds in percent, set per phase by the stimulus process.
  int send_idle_pct = 38;
  int recv_idle_pct = 72;
  // A long receiver hold-off is requested here and counted down by the receiver.
  int hold_req = 0;
  int hold_left = 0;

  int cycle_count = 0;
  int register_writes = 0;
  int input_stall_cycles = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  frame_motion_detect i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .new_pixel_i       (new_pixel),
    .old_pixel_i       (old_pixel),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .motion_detected_o (motion_detected_o),
    .changed_count_o   (changed_count_o),
    .box_left_o        (box_left_o),
    .box_top_o         (box_top_o),
    .box_right_o       (box_right_o),
    .box_bottom_o      (box_bottom_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Result side: sample the handshake at the edge, check a completed
  // transaction, then pick the stall for the next cycle.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_valid_o && !out_stall)
      sb.check_report({motion_detected_o, changed_count_o, box_left_o, box_top_o,
                       box_right_o, box_bottom_o});
    if (rst_n && in_valid && in_stall_o) input_stall_cycles++;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d reports outstanding",
               $time, cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one pixel pair, optionally after a random gap, and hold it until taken.
  task automatic send_pair(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] prev);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    new_pixel <= cur;
    old_pixel <= prev;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    sb.note_pixel(cur, prev);
  endtask

  // Mostly near-equal pairs so that the threshold decides, some fully random.
  task automatic send_random_pair();
    int r, cur, prev;
    cur = $urandom_range(255);
    r = $urandom_range(99);
    if (r < 40)
      prev = cur;
    else if (r < 70)
      prev = cur + $urandom_range(40) - 20;
    else
      prev = $urandom_range(255);
    if (prev < 0) prev = 0;
    if (prev > 255) prev = 255;
    send_pair(cur[PIX_W-1:0], prev[PIX_W-1:0]);
  endtask

  // Stream random pixels until the current frame closes.
  task automatic finish_frame();
    int target;
    target = sb.reports_predicted + 1;
    while (sb.reports_predicted < target) send_random_pair();
  endtask

  // Drop valid, wait for every outstanding report, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then the bus is released.
  task automatic set_register(input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(idx, data);
    register_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Frame sizes: mostly tiny, now and then zero (acts as one) or a little larger.
  function automatic int rand_size(int common_max, int rare_max);
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(rare_max, common_max + 1);
    return $urandom_range(common_max, 1);
  endfunction

  function automatic int rand_pix_thr();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 22) return 255;
    if (r < 45) return $urandom_range(255);
    return $urandom_range(40);
  endfunction

  function automatic int rand_count_thr();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 0;
    if (r < 28) return 21'h1FFFFF;
    if (r < 40) return $urandom_range(21'h1FFFFF);
    return $urandom_range(16);
  endfunction

  // One random frame: maybe reconfigure first, maybe resize part-way through.
  task automatic random_frame();
    int n;
    if ($urandom_range(99) >= 35) begin
      wait_idle();
      if ($urandom_range(1)) set_register(REG_FRAME_WIDTH, rand_size(8, 48));
      if ($urandom_range(1)) set_register(REG_FRAME_HEIGHT, rand_size(4, 16));
      if ($urandom_range(1)) set_register(REG_PIXEL_THRESHOLD, rand_pix_thr());
      if ($urandom_range(1)) set_register(REG_COUNT_THRESHOLD, rand_count_thr());
    end
    if ($urandom_range(7) == 0) begin
      n = $urandom_range(3, 1);
      repeat (n) send_random_pair();
      // Resize with the frame still open; the line/frame end follows the new size.
      wait_idle();
      if ($urandom_range(1))
        set_register(REG_FRAME_WIDTH, rand_size(8, 48));
      else
        set_register(REG_FRAME_HEIGHT, rand_size(4, 16));
    end
    finish_frame();
  endtask

  initial begin
    int target;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 4x2 frame, every pixel above a zero threshold except equal pairs.
    set_register(REG_FRAME_WIDTH, 4);
    set_register(REG_FRAME_HEIGHT, 2);
    set_register(REG_PIXEL_THRESHOLD, 0);
    set_register(REG_COUNT_THRESHOLD, 0);
    send_pair(8'd0, 8'd0);
    send_pair(8'd255, 8'd0);
    send_pair(8'd0, 8'd255);
    send_pair(8'd1, 8'd0);
    send_pair(8'd0, 8'd1);
    send_pair(8'd128, 8'd128);
    send_pair(8'd127, 8'd128);
    send_pair(8'd255, 8'd255);

    // Empty frame: full-scale difference not above the top threshold.
    wait_idle();
    set_register(REG_FRAME_WIDTH, 1);
    set_register(REG_FRAME_HEIGHT, 1);
    set_register(REG_PIXEL_THRESHOLD, 255);
    send_pair(8'd255, 8'd0);

    // Zero sizes act as one pixel per frame.
    wait_idle();
    set_register(REG_PIXEL_THRESHOLD, 254);
    set_register(REG_FRAME_WIDTH, 0);
    set_register(REG_FRAME_HEIGHT, 0);
    send_pair(8'd0, 8'd255);

    // Shrink the width and then the height with a frame half done.
    wait_idle();
    set_register(REG_FRAME_WIDTH, 5);
    set_register(REG_FRAME_HEIGHT, 3);
    set_register(REG_PIXEL_THRESHOLD, 10);
    set_register(REG_COUNT_THRESHOLD, 1);
    repeat (3) send_random_pair();
    wait_idle();
    set_register(REG_FRAME_WIDTH, 2);
    repeat (2) send_random_pair();
    wait_idle();
    set_register(REG_FRAME_HEIGHT, 1);
    finish_frame();

    // Oversized width clamps to the maximum: one full-width line.
    wait_idle();
    set_register(REG_FRAME_WIDTH, 2047);
    set_register(REG_FRAME_HEIGHT, 1);
    set_register(REG_PIXEL_THRESHOLD, 128);
    set_register(REG_COUNT_THRESHOLD, 21'h1FFFFF);
    finish_frame();

    // Back-pressure: hold the result side off while tiny frames keep coming,
    // so a finished frame waits and the input stalls behind it.
    wait_idle();
    set_register(REG_FRAME_WIDTH, 3);
    set_register(REG_FRAME_HEIGHT, 2);
    set_register(REG_PIXEL_THRESHOLD, 8);
    set_register(REG_COUNT_THRESHOLD, 2);
    send_idle_pct = 0;
    hold_req = 300;
    repeat (5) finish_frame();
    wait_idle();

    // Random frames under three idling patterns.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = sb.pixels_seen + 35;
      while (sb.pixels_seen < target) random_frame();
    end

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Run covered %0d pixel transactions, %0d register writes, %0d input stall cycles",
             sb.pixels_seen, register_writes, input_stall_cycles);
    $display("Frame reports checked: %0d of %0d, %0d with motion, %0d mismatches",
             sb.reports_checked, sb.reports_predicted, sb.motion_reports, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### frame_motion_detect.f
hw/rtl/fmd_pkg.sv
hw/rtl/fmd_cfg.sv
hw/rtl/fmd_accum.sv
hw/rtl/frame_motion_detect.sv
tb/tb_frame_motion_detect.sv
